### sv/dpd_pkg.sv
`timescale 1ns / 1ps

package dpd_pkg;

   localparam int MAX_TASKS = 32;
   localparam int SLOT_W    = $clog2(MAX_TASKS);
   localparam int PRI_W     = 8;
   localparam int DUR_W     = 16;

   typedef logic [MAX_TASKS-1:0] task_set_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [PRI_W-1:0]     pri_type;
   typedef logic [DUR_W-1:0]     dur_type;

   typedef enum logic [1:0] {
      FUNC_LOAD     = 2'd0,
      FUNC_START    = 2'd1,
      FUNC_DISPATCH = 2'd2,
      FUNC_COMPLETE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_CYCLE  = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_DENIED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_READ,
      SEQ_EVAL,
      SEQ_DONE
   } seq_type;

   typedef struct packed {
      func_type     func;
      slot_type     slot;
      pri_type      prio;
      dur_type      duration;
      task_set_type mask;
   } item_type;

   typedef struct packed {
      status_type status;
      logic       granted_valid;
      slot_type   granted_slot;
      dur_type    granted_duration;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

   typedef struct packed {
      func_type     op;
      slot_type     idx;
      slot_type     slot;
      task_set_type dep_word;
      pri_type      pri_word;
      task_set_type defined;
      task_set_type peeled;
      task_set_type ready;
      logic         have_best;
      pri_type      best_pri;
   } eval_in_type;

   typedef struct packed {
      logic         dep_we;
      task_set_type dep_wdata;
      logic         peel_hit;
      logic         zero_dep;
      logic         cand_hit;
   } eval_out_type;

endpackage

### sv/dpd_eval_unit.sv
`timescale 1ns / 1ps

module dpd_eval_unit
   import dpd_pkg::*;
(
   input  eval_in_type  ev_in,
   output eval_out_type ev_out
);

   task_set_type masked;
   task_set_type cleared;
   task_set_type slot_bit;
   logic         def_bit;

   assign def_bit  = ev_in.defined[ev_in.idx];
   assign masked   = ev_in.dep_word & ev_in.defined;
   assign slot_bit = task_set_type'(1) << ev_in.slot;
   assign cleared  = ev_in.dep_word & ~slot_bit;

   always_comb begin
      ev_out = '0;
      case (ev_in.op)
         FUNC_START: begin
            // drop links to unloaded tasks; peel when every remaining link is peeled
            ev_out.dep_we    = def_bit;
            ev_out.dep_wdata = masked;
            ev_out.peel_hit  = def_bit && !ev_in.peeled[ev_in.idx]
                               && ((masked & ~ev_in.peeled) == '0);
            ev_out.zero_dep  = def_bit && (masked == '0);
         end
         FUNC_COMPLETE: begin
            ev_out.dep_we    = def_bit && ev_in.dep_word[ev_in.slot];
            ev_out.dep_wdata = cleared;
            ev_out.zero_dep  = def_bit && ev_in.dep_word[ev_in.slot] && (cleared == '0);
         end
         FUNC_DISPATCH: begin
            ev_out.cand_hit = ev_in.ready[ev_in.idx]
                              && (!ev_in.have_best || (ev_in.pri_word < ev_in.best_pri));
         end
         default: begin
            ev_out = '0;
         end
      endcase
   end

endmodule

### sv/dpd_engine.sv
`timescale 1ns / 1ps

module dpd_engine
   import dpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  item_type     item,
   input  logic         sink_ready,
   output eng_stat_type stat,
   output result_type   result
);

   // task tables; dependency words turn into pending words at start
   pri_type      pri_mem [MAX_TASKS];
   dur_type      dur_mem [MAX_TASKS];
   task_set_type dep_mem [MAX_TASKS];

   seq_type      state_ff, state_in;
   item_type     item_ff, item_in;
   slot_type     cnt_ff, cnt_in;
   task_set_type defined_ff, defined_in;
   task_set_type ready_ff, ready_in;
   task_set_type dispatched_ff, dispatched_in;
   logic         started_ff, started_in;
   task_set_type peeled_ff, peeled_in;
   task_set_type zero_ff, zero_in;
   logic         changed_ff, changed_in;
   logic         have_best_ff, have_best_in;
   slot_type     best_idx_ff, best_idx_in;
   pri_type      best_pri_ff, best_pri_in;
   dur_type      best_dur_ff, best_dur_in;
   result_type   result_ff, result_in;

   pri_type      pri_rd_ff;
   dur_type      dur_rd_ff;
   task_set_type dep_rd_ff;

   logic         tbl_we;
   logic         dep_we;
   slot_type     wr_addr;
   task_set_type dep_wdata;

   eval_in_type  ev_in;
   eval_out_type ev_out;

   task_set_type idx_bit;
   task_set_type slot_bit;
   task_set_type best_bit;
   task_set_type peeled_now;
   task_set_type zero_now;
   logic         last_idx;
   logic         pass_more;

   assign idx_bit    = task_set_type'(1) << cnt_ff;
   assign slot_bit   = task_set_type'(1) << item_ff.slot;
   assign best_bit   = task_set_type'(1) << best_idx_in;
   assign last_idx   = (cnt_ff == slot_type'(MAX_TASKS - 1));
   assign peeled_now = ev_out.peel_hit ? (peeled_ff | idx_bit) : peeled_ff;
   assign zero_now   = ev_out.zero_dep ? (zero_ff | idx_bit) : zero_ff;
   assign pass_more  = changed_ff || ev_out.peel_hit;

   assign ev_in.op        = item_ff.func;
   assign ev_in.idx       = cnt_ff;
   assign ev_in.slot      = item_ff.slot;
   assign ev_in.dep_word  = dep_rd_ff;
   assign ev_in.pri_word  = pri_rd_ff;
   assign ev_in.defined   = defined_ff;
   assign ev_in.peeled    = peeled_ff;
   assign ev_in.ready     = ready_ff;
   assign ev_in.have_best = have_best_ff;
   assign ev_in.best_pri  = best_pri_ff;

   dpd_eval_unit u_eval (
      .ev_in  (ev_in),
      .ev_out (ev_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (go) state_in = SEQ_DECODE;
         end
         SEQ_DECODE: begin
            case (item_ff.func)
               FUNC_LOAD:     state_in = SEQ_DONE;
               FUNC_START:    state_in = started_ff ? SEQ_DONE : SEQ_READ;
               FUNC_DISPATCH: state_in = (!started_ff || ready_ff == '0) ? SEQ_DONE : SEQ_READ;
               FUNC_COMPLETE: state_in = (!started_ff || !dispatched_ff[item_ff.slot])
                                         ? SEQ_DONE : SEQ_READ;
               default:       state_in = SEQ_DONE;
            endcase
         end
         SEQ_READ: begin
            state_in = SEQ_EVAL;
         end
         SEQ_EVAL: begin
            if (!last_idx) begin
               state_in = SEQ_READ;
            end else if (item_ff.func == FUNC_START && pass_more) begin
               state_in = SEQ_READ;
            end else begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (sink_ready) state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // datapath and sets
   always_comb begin
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      defined_in    = defined_ff;
      ready_in      = ready_ff;
      dispatched_in = dispatched_ff;
      started_in    = started_ff;
      peeled_in     = peeled_ff;
      zero_in       = zero_ff;
      changed_in    = changed_ff;
      have_best_in  = have_best_ff;
      best_idx_in   = best_idx_ff;
      best_pri_in   = best_pri_ff;
      best_dur_in   = best_dur_ff;
      result_in     = result_ff;
      tbl_we        = 1'b0;
      dep_we        = 1'b0;
      wr_addr       = cnt_ff;
      dep_wdata     = ev_out.dep_wdata;
      case (state_ff)
         SEQ_IDLE: begin
            if (go) item_in = item;
         end
         SEQ_DECODE: begin
            result_in = '0;
            cnt_in    = '0;
            case (item_ff.func)
               FUNC_LOAD: begin
                  if (started_ff) begin
                     result_in.status = STAT_DENIED;
                  end else begin
                     tbl_we     = 1'b1;
                     dep_we     = 1'b1;
                     wr_addr    = item_ff.slot;
                     dep_wdata  = item_ff.mask;
                     defined_in = defined_ff | slot_bit;
                     result_in.status = STAT_OK;
                  end
               end
               FUNC_START: begin
                  result_in.status = STAT_DENIED;
                  peeled_in  = '0;
                  zero_in    = '0;
                  changed_in = 1'b0;
               end
               FUNC_DISPATCH: begin
                  result_in.status = !started_ff ? STAT_DENIED
                                   : (ready_ff == '0) ? STAT_EMPTY : STAT_OK;
                  have_best_in = 1'b0;
               end
               FUNC_COMPLETE: begin
                  if (!started_ff || !dispatched_ff[item_ff.slot]) begin
                     result_in.status = STAT_DENIED;
                  end else begin
                     dispatched_in    = dispatched_ff & ~slot_bit;
                     result_in.status = STAT_OK;
                  end
               end
               default: begin
                  result_in.status = STAT_DENIED;
               end
            endcase
         end
         SEQ_EVAL: begin
            cnt_in = cnt_ff + slot_type'(1);
            case (item_ff.func)
               FUNC_START: begin
                  dep_we     = ev_out.dep_we;
                  peeled_in  = peeled_now;
                  zero_in    = zero_now;
                  changed_in = pass_more;
                  if (last_idx) begin
                     changed_in = 1'b0;
                     if (!pass_more) begin
                        if (peeled_now == defined_ff) begin
                           ready_in         = zero_now;
                           dispatched_in    = '0;
                           started_in       = 1'b1;
                           result_in.status = STAT_OK;
                        end else begin
                           result_in.status = STAT_CYCLE;
                        end
                     end
                  end
               end
               FUNC_DISPATCH: begin
                  if (ev_out.cand_hit) begin
                     have_best_in = 1'b1;
                     best_idx_in  = cnt_ff;
                     best_pri_in  = pri_rd_ff;
                     best_dur_in  = dur_rd_ff;
                  end
                  if (last_idx) begin
                     ready_in      = ready_ff & ~best_bit;
                     dispatched_in = dispatched_ff | best_bit;
                     result_in.granted_valid    = 1'b1;
                     result_in.granted_slot     = best_idx_in;
                     result_in.granted_duration = best_dur_in;
                  end
               end
               FUNC_COMPLETE: begin
                  dep_we = ev_out.dep_we;
                  if (ev_out.zero_dep) ready_in = ready_ff | idx_bit;
               end
               default: begin
                  dep_we = 1'b0;
               end
            endcase
         end
         default: begin
            tbl_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         defined_ff    <= '0;
         ready_ff      <= '0;
         dispatched_ff <= '0;
         started_ff    <= 1'b0;
         cnt_ff        <= '0;
         changed_ff    <= 1'b0;
         have_best_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         defined_ff    <= defined_in;
         ready_ff      <= ready_in;
         dispatched_ff <= dispatched_in;
         started_ff    <= started_in;
         cnt_ff        <= cnt_in;
         changed_ff    <= changed_in;
         have_best_ff  <= have_best_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      peeled_ff   <= peeled_in;
      zero_ff     <= zero_in;
      best_idx_ff <= best_idx_in;
      best_pri_ff <= best_pri_in;
      best_dur_ff <= best_dur_in;
      result_ff   <= result_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         pri_mem[wr_addr] <= item_ff.prio;
         dur_mem[wr_addr] <= item_ff.duration;
      end
      if (dep_we) dep_mem[wr_addr] <= dep_wdata;
      pri_rd_ff <= pri_mem[cnt_ff];
      dur_rd_ff <= dur_mem[cnt_ff];
      dep_rd_ff <= dep_mem[cnt_ff];
   end

   assign stat.idle = (state_ff == SEQ_IDLE);
   assign stat.done = (state_ff == SEQ_DONE);
   assign result    = result_ff;

`ifndef SYNTHESIS
   a_ready_not_dispatched: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & dispatched_ff) == '0)
      else $error("task both ready and dispatched");

   a_ready_defined: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & ~defined_ff) == '0)
      else $error("ready task was never loaded");

   a_idle_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (ready_ff == '0 && dispatched_ff == '0))
      else $error("ready or dispatched bits before start");

   a_start_source: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> $past(item_ff.func) == FUNC_START)
      else $error("started without a start word");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DONE && result_ff.granted_valid) |-> result_ff.status == STAT_OK)
      else $error("grant with error status");
`endif

endmodule

### sv/dependency_priority_dispatcher.sv
`timescale 1ns / 1ps
// Dependency priority dispatcher.
// Input stream (req_): one word per command; req_tuser selects load, start,
// dispatch or complete. Output stream (rsp_): exactly one word per command,
// in command order, carrying the status and, for dispatch, the granted task.
// One command is processed at a time; req_tready is high only while the
// sequencer is idle. Load, and any rejected command, finishes in the decode step.
// Dispatch and complete walk the task table once through the shared evaluate
// unit, with a table read and then an evaluate step for each slot. Start repeats
// that walk until a pass peels nothing new, at most 33 passes. The table has
// one read port, which sets the walk rate. The next command can be accepted as
// soon as rsp_tvalid rises, since the sequencer returns to idle together with it.
// Reset clears the loaded, ready and dispatched sets and the started flag;
// the task tables need no clearing. After start, only reset returns the block
// to loading. If rsp_tready is held low, one finished result waits in the
// output register while the next command is processed; a second result then
// holds in the sequencer and req_tready stays low until the output drains.

module dependency_priority_dispatcher
   import dpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] task_slot, [12:5] task_priority, [28:13] task_duration,
   // [60:29] depends_mask, [63:61] zero
   input  logic [63:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] granted_slot, [20:5] granted_duration, [23:21] zero
   output logic [23:0] rsp_tdata,
   // [1:0] status, [2] granted_valid
   output logic [2:0]  rsp_tuser
);

   eng_stat_type stat;
   result_type   eng_result;
   item_type     item;
   logic         go;
   logic         out_free;

   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_word_ff, rsp_word_in;

   assign item.func     = func_type'(req_tuser);
   assign item.slot     = req_tdata[4:0];
   assign item.prio     = req_tdata[12:5];
   assign item.duration = req_tdata[28:13];
   assign item.mask     = req_tdata[60:29];

   assign req_tready = stat.idle;
   assign go         = req_tvalid && stat.idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   dpd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .item       (item),
      .sink_ready (out_free),
      .stat       (stat),
      .result     (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (stat.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = eng_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_word_ff.granted_duration, rsp_word_ff.granted_slot};
   assign rsp_tuser  = {rsp_word_ff.granted_valid, rsp_word_ff.status};

endmodule

### tb/dispatch_check.sv
`timescale 1ns / 1ps

module dispatch_check
   import dpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          mismatch_count,
   output int          words_outstanding
);

   task_set_type loaded_set, ready_set, issued_set;
   logic         started;
   pri_type      pri_tab  [MAX_TASKS];
   dur_type      dur_tab  [MAX_TASKS];
   task_set_type dep_tab  [MAX_TASKS];
   task_set_type wait_tab [MAX_TASKS];
   result_type   grant_q  [$];

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Advances the scheduler state by one command and returns the word it must produce.
   function automatic result_type predict_word(func_type op, slot_type s, pri_type p,
                                               dur_type d, task_set_type m);
      result_type   r;
      task_set_type peeled, round;
      int           best;
      r = '0;
      r.status = STAT_OK;
      case (op)
         FUNC_LOAD: begin
            if (started) begin
               r.status = STAT_DENIED;
            end else begin
               pri_tab[s] = p;
               dur_tab[s] = d;
               dep_tab[s] = m;
               loaded_set[s] = 1'b1;
            end
         end
         FUNC_START: begin
            if (started) begin
               r.status = STAT_DENIED;
            end else begin
               // deps on unloaded slots are dropped for good, even if a cycle is found
               for (int i = 0; i < MAX_TASKS; i++)
                  if (loaded_set[i]) dep_tab[i] &= loaded_set;
               peeled = '0;
               do begin
                  round = '0;
                  for (int i = 0; i < MAX_TASKS; i++)
                     if (loaded_set[i] && !peeled[i] && (dep_tab[i] & ~peeled) == '0)
                        round[i] = 1'b1;
                  peeled |= round;
               end while (round != '0);
               if (peeled != loaded_set) begin
                  r.status = STAT_CYCLE;
               end else begin
                  ready_set = '0;
                  issued_set = '0;
                  for (int i = 0; i < MAX_TASKS; i++) begin
                     if (loaded_set[i]) begin
                        wait_tab[i] = dep_tab[i];
                        if (dep_tab[i] == '0) ready_set[i] = 1'b1;
                     end
                  end
                  started = 1'b1;
               end
            end
         end
         FUNC_DISPATCH: begin
            if (!started) begin
               r.status = STAT_DENIED;
            end else if (ready_set == '0) begin
               r.status = STAT_EMPTY;
            end else begin
               best = -1;
               for (int i = 0; i < MAX_TASKS; i++)
                  if (ready_set[i] && (best < 0 || pri_tab[i] < pri_tab[best])) best = i;
               ready_set[best] = 1'b0;
               issued_set[best] = 1'b1;
               r.granted_valid = 1'b1;
               r.granted_slot = slot_type'(best);
               r.granted_duration = dur_tab[best];
            end
         end
         default: begin
            if (!started || !issued_set[s]) begin
               r.status = STAT_DENIED;
            end else begin
               issued_set[s] = 1'b0;
               for (int i = 0; i < MAX_TASKS; i++) begin
                  if (loaded_set[i] && wait_tab[i][s]) begin
                     wait_tab[i][s] = 1'b0;
                     if (wait_tab[i] == '0) ready_set[i] = 1'b1;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         loaded_set = '0;
         ready_set = '0;
         issued_set = '0;
         started = 1'b0;
         grant_q.delete();
      end else begin
         // response first: a word accepted on this edge cannot answer a command of this edge
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               report_mismatch("response word with nothing pending", {rsp_tuser, rsp_tdata}, 0);
            end else begin
               want = grant_q.pop_front();
               if (rsp_tuser[1:0] !== want.status)
                  report_mismatch("status", rsp_tuser[1:0], want.status);
               if (rsp_tuser[2] !== want.granted_valid)
                  report_mismatch("granted_valid", rsp_tuser[2], want.granted_valid);
               if (rsp_tdata[4:0] !== want.granted_slot)
                  report_mismatch("granted_slot", rsp_tdata[4:0], want.granted_slot);
               if (rsp_tdata[20:5] !== want.granted_duration)
                  report_mismatch("granted_duration", rsp_tdata[20:5], want.granted_duration);
            end
         end
         if (req_tvalid && req_tready)
            grant_q = {grant_q, predict_word(func_type'(req_tuser), req_tdata[4:0],
                                             req_tdata[12:5], req_tdata[28:13],
                                             req_tdata[60:29])};
      end
      words_outstanding <= grant_q.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench
   import dpd_pkg::*;
();

   localparam int STALL_LIMIT  = 20000;
   localparam int TRIAL_WORDS  = 1400;
   localparam int POST_WORDS   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_FIRST   = 600;
   localparam int CALM_LAST    = 900;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   int          mismatch_count;
   int          words_outstanding;

   int           words_sent;
   int           words_back;
   task_set_type slot_pool;
   slot_type     pool_list [$];
   slot_type     granted_q [$];

   dependency_priority_dispatcher DUT (.*);

   dispatch_check grant_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) words_back <= words_back + 1;

   // Grants are noted on the falling edge ahead of the accepting edge, so the sender never
   // races the record of what it may complete.
   always @(negedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tuser[2])
         granted_q = {granted_q, slot_type'(rsp_tdata[4:0])};

   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && words_back >= 150) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= (words_back >= CALM_FIRST && words_back < CALM_LAST) ||
                       ($urandom_range(99) >= 9);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_word(func_type op, slot_type s, pri_type p, dur_type d,
                            task_set_type m);
      while (!(words_sent >= CALM_FIRST && words_sent < CALM_LAST) &&
             $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, m, d, p, s};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_noise(func_type op);
      send_word(op, slot_type'($urandom), pri_type'($urandom), dur_type'($urandom),
                task_set_type'($urandom));
   endtask

   task automatic load_random(slot_type s, task_set_type m);
      send_word(FUNC_LOAD, s, pri_type'($urandom), dur_type'($urandom), m);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
   endtask

   function automatic task_set_type random_mask();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return task_set_type'(1) << $urandom_range(MAX_TASKS - 1);
         default: return task_set_type'($urandom);
      endcase
   endfunction

   // Random loads or stray words, then a planted loop of pool slots so start must fail.
   task automatic run_cyclic_trial();
      int       ia, ib, ic, off;
      slot_type a, b, c;
      repeat ($urandom_range(1, 7)) begin
         if ($urandom_range(9) == 0)
            send_noise(func_type'($urandom_range(FUNC_DISPATCH, FUNC_COMPLETE)));
         else
            load_random(pool_list[$urandom_range(pool_list.size() - 1)], random_mask());
      end
      ia = $urandom_range(pool_list.size() - 1);
      a = pool_list[ia];
      case ($urandom_range(2))
         0: load_random(a, random_mask() | (task_set_type'(1) << a));
         1: begin
            b = pool_list[(ia + $urandom_range(1, pool_list.size() - 1)) % pool_list.size()];
            load_random(a, random_mask() | (task_set_type'(1) << b));
            load_random(b, random_mask() | (task_set_type'(1) << a));
         end
         default: begin
            if (pool_list.size() < 3) begin
               load_random(a, random_mask() | (task_set_type'(1) << a));
            end else begin
               off = $urandom_range(1, pool_list.size() - 2);
               ib = (ia + off) % pool_list.size();
               ic = (ia + $urandom_range(off + 1, pool_list.size() - 1)) % pool_list.size();
               b = pool_list[ib];
               c = pool_list[ic];
               load_random(a, random_mask() | (task_set_type'(1) << b));
               load_random(b, random_mask() | (task_set_type'(1) << c));
               load_random(c, random_mask() | (task_set_type'(1) << a));
            end
         end
      endcase
      send_noise(FUNC_START);
   endtask

   // Reload every pool slot in a random order, each depending only on earlier ones
   // (plus unloaded slots, which start must drop), then start for real.
   task automatic load_task_graph();
      slot_type     order [$];
      slot_type     tmp;
      task_set_type m;
      int           j, dens;
      order = pool_list;
      for (int i = order.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      dens = $urandom_range(2, 30);
      for (int k = 0; k < order.size(); k++) begin
         m = '0;
         for (int e = 0; e < k; e++)
            if ($urandom_range(99) < dens) m[order[e]] = 1'b1;
         if ($urandom_range(2) == 0) m |= task_set_type'($urandom) & ~slot_pool;
         send_word(FUNC_LOAD, order[k],
                   $urandom_range(1) ? pri_type'($urandom_range(3)) : pri_type'($urandom),
                   dur_type'($urandom), m);
      end
      send_noise(FUNC_START);
   endtask

   task automatic run_dispatch_phase();
      int       r, pick;
      slot_type s;
      repeat (POST_WORDS) begin
         r = $urandom_range(99);
         if (r < 45 && granted_q.size() > 0) begin
            pick = $urandom_range(granted_q.size() - 1);
            s = granted_q[pick];
            granted_q.delete(pick);
            send_word(FUNC_COMPLETE, s, pri_type'($urandom), dur_type'($urandom),
                      task_set_type'($urandom));
         end else if (r < 88) begin
            send_noise(FUNC_DISPATCH);
         end else begin
            // stray commands: repeated start, late load, bogus or repeated completion
            send_noise(func_type'($urandom_range(FUNC_COMPLETE)));
         end
      end
   endtask

   initial begin : stimulus
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_LOAD;
      words_sent = 0;
      words_back <= 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      slot_pool = ($urandom_range(1) ? '1 : task_set_type'($urandom)) | 32'h8000_0001;
      for (int i = 0; i < MAX_TASKS; i++)
         if (slot_pool[i]) pool_list = {pool_list, slot_type'(i)};

      // not started yet: dispatch and completion are refused
      send_noise(FUNC_DISPATCH);
      send_noise(FUNC_COMPLETE);
      send_word(FUNC_LOAD, slot_type'(0), '0, '0, '0);
      send_word(FUNC_LOAD, slot_type'(31), '1, '1, '1);
      send_noise(FUNC_START);
      // overwrite both slots to form a two-task loop
      send_word(FUNC_LOAD, slot_type'(31), pri_type'(7), dur_type'(16'h8000), 32'h0000_0001);
      send_word(FUNC_LOAD, slot_type'(0), '1, dur_type'(1), 32'h8000_0100);
      send_noise(FUNC_START);

      while (words_sent < TRIAL_WORDS) run_cyclic_trial();

      wait_drained();
      load_task_graph();

      send_noise(FUNC_START);
      send_noise(FUNC_LOAD);
      send_word(FUNC_COMPLETE, pool_list[0], '0, '0, '0);
      send_noise(FUNC_DISPATCH);
      run_dispatch_phase();

      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && words_outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
sv/dpd_pkg.sv
sv/dpd_eval_unit.sv
sv/dpd_engine.sv
sv/dependency_priority_dispatcher.sv
tb/dispatch_check.sv
tb/testbench.sv
